@@ hw/rtl/generator_autostart_controller_macros.svh @@
// ----------------------------------------------------------------------------
// Generator autostart controller assertion macros
// Shared immediate-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef GENERATOR_AUTOSTART_CONTROLLER_MACROS_SVH
`define GENERATOR_AUTOSTART_CONTROLLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gac assertion failed");

// antecedent implies consequent in the following cycle
`define GAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gac assertion failed");

`endif

@@ hw/rtl/gac_pkg.sv @@
// ----------------------------------------------------------------------------
// Generator autostart controller package
// Register indexes, reset values, widths and shared types.
// ----------------------------------------------------------------------------
package gac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int TDATA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_WAIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = 3'd4;

    localparam logic [3:0] RST_DEBOUNCE   = 4'd6;
    localparam logic [7:0] RST_COOLDOWN   = 8'd80;
    localparam logic [7:0] RST_START_WAIT = 8'd60;
    localparam logic [2:0] RST_MAX_RETRY  = 3'd3;
    localparam logic [7:0] RST_WARMUP     = 8'd15;

    localparam logic [7:0] COOL_SAT    = 8'd255;
    localparam logic [8:0] ATTEMPT_SAT = 9'd511;

    typedef struct packed {
        logic [3:0] debounce_ticks;
        logic [7:0] cooldown_ticks;
        logic [7:0] start_wait_ticks;
        logic [2:0] max_retries;
        logic [7:0] warmup_ticks;
    } t_cfg;

    typedef struct packed {
        logic request_led;
        logic running_led;
        logic cooldown_led;
        logic locked_out;
        logic stop_pulse;
        logic start_pulse;
    } t_result;

endpackage

@@ hw/rtl/gac_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Generator autostart controller configuration registers
// Write-only register file decoded from the plain write port.
// ----------------------------------------------------------------------------
module gac_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [gac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gac_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output gac_pkg::t_cfg                   o_cfg
);

    gac_pkg::t_cfg r_cfg;
    gac_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                gac_pkg::CFG_DEBOUNCE:   n_cfg.debounce_ticks   = i_cfg_wdata[3:0];
                gac_pkg::CFG_COOLDOWN:   n_cfg.cooldown_ticks   = i_cfg_wdata;
                gac_pkg::CFG_START_WAIT: n_cfg.start_wait_ticks = i_cfg_wdata;
                gac_pkg::CFG_MAX_RETRY:  n_cfg.max_retries      = i_cfg_wdata[2:0];
                gac_pkg::CFG_WARMUP:     n_cfg.warmup_ticks     = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= gac_pkg::RST_DEBOUNCE;
            r_cfg.cooldown_ticks   <= gac_pkg::RST_COOLDOWN;
            r_cfg.start_wait_ticks <= gac_pkg::RST_START_WAIT;
            r_cfg.max_retries      <= gac_pkg::RST_MAX_RETRY;
            r_cfg.warmup_ticks     <= gac_pkg::RST_WARMUP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/gac_core.sv @@
// ----------------------------------------------------------------------------
// Generator autostart controller tick core
// Controller state and the single-pass update for one control tick.
// ----------------------------------------------------------------------------
module gac_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gac_pkg::t_cfg    i_cfg,
    input  logic             i_fire,
    input  logic             i_running_sense_n,
    input  logic             i_line_fail_n,
    output gac_pkg::t_result o_result
);

    logic       r_gen_running, n_gen_running;
    logic       r_power_req,   n_power_req;
    logic [4:0] r_stable_cnt,  n_stable_cnt;
    logic [7:0] r_cool_cnt,    n_cool_cnt;
    logic [8:0] r_attempt_cnt, n_attempt_cnt;
    logic [2:0] r_retry_cnt,   n_retry_cnt;
    logic [8:0] r_tick_cnt,    n_tick_cnt;
    logic       r_cool_led,    n_cool_led;
    logic       r_run_led,     n_run_led;

    logic       locked;
    logic       running_now;
    logic       request_now;
    logic [7:0] cool_inc;
    logic [8:0] attempt_inc;
    logic [8:0] warmup_ext;

    always_comb begin
        warmup_ext  = {1'b0, i_cfg.warmup_ticks};
        running_now = !i_running_sense_n;
        request_now = !i_line_fail_n;
        locked      = (r_retry_cnt >= i_cfg.max_retries);
        cool_inc    = (r_cool_cnt < gac_pkg::COOL_SAT) ? r_cool_cnt + 8'd1 : r_cool_cnt;
        attempt_inc = (r_attempt_cnt < gac_pkg::ATTEMPT_SAT) ?
                      r_attempt_cnt + 9'd1 : r_attempt_cnt;

        n_tick_cnt    = (r_tick_cnt <= warmup_ext) ? r_tick_cnt + 9'd1 : r_tick_cnt;
        n_gen_running = r_gen_running;
        n_power_req   = r_power_req;
        n_stable_cnt  = r_stable_cnt;
        n_cool_cnt    = r_cool_cnt;
        n_attempt_cnt = r_attempt_cnt;
        n_retry_cnt   = r_retry_cnt;
        n_cool_led    = 1'b0;
        n_run_led     = 1'b0;
        o_result      = '0;

        if (locked) begin
            o_result.locked_out = 1'b1;
        end else begin
            if (running_now && !r_gen_running) begin
                if (r_stable_cnt > {1'b0, i_cfg.debounce_ticks}) begin
                    n_gen_running = 1'b1;
                end else begin
                    n_stable_cnt = r_stable_cnt + 5'd1;
                end
            end else begin
                n_gen_running = running_now;
                n_stable_cnt  = '0;
            end
            n_power_req = request_now;

            n_cool_led = (r_cool_cnt != '0) ? !r_cool_led : 1'b0;
            n_run_led  = (n_stable_cnt != '0) ? !r_run_led : n_gen_running;

            if (n_gen_running) begin
                n_attempt_cnt = '0;
                n_retry_cnt   = '0;
                if (request_now) begin
                    n_cool_cnt = '0;
                end else if (cool_inc >= i_cfg.cooldown_ticks) begin
                    o_result.stop_pulse = 1'b1;
                    n_cool_cnt          = '0;
                end else begin
                    n_cool_cnt = cool_inc;
                end
            end else begin
                n_cool_cnt = '0;
                if (request_now && (n_tick_cnt > warmup_ext) && (n_stable_cnt == '0)) begin
                    o_result.start_pulse = (r_attempt_cnt == '0);
                    if ((attempt_inc > {1'b0, i_cfg.start_wait_ticks}) &&
                        (r_retry_cnt < i_cfg.max_retries)) begin
                        n_attempt_cnt = '0;
                        n_retry_cnt   = r_retry_cnt + 3'd1;
                    end else begin
                        n_attempt_cnt = attempt_inc;
                    end
                end else begin
                    n_attempt_cnt = '0;
                    n_retry_cnt   = '0;
                end
            end

            o_result.cooldown_led = n_cool_led;
            o_result.running_led  = n_run_led;
            o_result.request_led  = n_power_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_running <= 1'b0;
            r_power_req   <= 1'b0;
            r_stable_cnt  <= '0;
            r_cool_cnt    <= '0;
            r_attempt_cnt <= '0;
            r_retry_cnt   <= '0;
            r_tick_cnt    <= '0;
            r_cool_led    <= 1'b0;
            r_run_led     <= 1'b0;
        end else if (i_fire) begin
            r_gen_running <= n_gen_running;
            r_power_req   <= n_power_req;
            r_stable_cnt  <= n_stable_cnt;
            r_cool_cnt    <= n_cool_cnt;
            r_attempt_cnt <= n_attempt_cnt;
            r_retry_cnt   <= n_retry_cnt;
            r_tick_cnt    <= n_tick_cnt;
            r_cool_led    <= n_cool_led;
            r_run_led     <= n_run_led;
        end
    end

endmodule

@@ hw/rtl/generator_autostart_controller.sv @@
// ----------------------------------------------------------------------------
// Generator autostart controller
// Debounces the running sense, times warm-up, cooldown and start attempts,
// and issues start and stop pulses with a permanent lockout on retries.
// ----------------------------------------------------------------------------
// One control tick is taken per clock cycle while the result side does not
// stall, and each gives exactly one result. A tick passes through an input
// register and then a result register; the controller state is updated as
// the tick moves into the result register. Input is held off only while both
// registers are full and the result side stalls. Configuration writes take
// effect on the next cycle and are meant for idle periods.
module generator_autostart_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // bit 0 running_sense_n, bit 1 line_fail_n, bits 7:2 zero
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [gac_pkg::TDATA_W-1:0]     i_s_tdata,
    // bit 0 start_pulse, 1 stop_pulse, 2 locked_out, 3 cooldown_led,
    // 4 running_led, 5 request_led, bits 7:6 zero
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [gac_pkg::TDATA_W-1:0]     o_m_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [gac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gac_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    gac_pkg::t_cfg    cfg;
    gac_pkg::t_result result;

    logic       r_in_valid;
    logic [1:0] r_in_data;
    logic       r_out_valid;
    logic [5:0] r_out_data;
    logic       out_free;
    logic       advance;
    logic       in_fire;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign in_fire    = i_s_tvalid && o_s_tready;

    gac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    gac_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_fire            (advance),
        .i_running_sense_n (r_in_data[0]),
        .i_line_fail_n     (r_in_data[1]),
        .o_result          (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= i_s_tdata[1:0];
        end
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_data};

endmodule

@@ hw/rtl/gac_checker.sv @@
// ----------------------------------------------------------------------------
// Generator autostart controller port checker
// Watches the top-level ports for result encoding and flow control slips.
// ----------------------------------------------------------------------------
`include "generator_autostart_controller_macros.svh"

module gac_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [gac_pkg::TDATA_W-1:0] o_m_tdata
);

    logic m_stall;
    logic m_locked;

    assign m_stall  = o_m_tvalid && !i_m_tready;
    assign m_locked = o_m_tvalid && o_m_tdata[2];

    `GAC_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, m_stall, o_m_tvalid && $stable(o_m_tdata))
    `GAC_ASSERT_SAME(a_one_pulse, i_clk, i_rst_n, o_m_tvalid, !(o_m_tdata[0] && o_m_tdata[1]))
    `GAC_ASSERT_SAME(a_lockout_quiet, i_clk, i_rst_n, m_locked, o_m_tdata[5:0] == 6'b000100)
    `GAC_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, !o_s_tready, m_stall)

endmodule

bind generator_autostart_controller gac_checker u_gac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Generator autostart controller testbench
// Streams control ticks through the controller under several register
// settings. A tick-level predictor derives the expected indications of every
// accepted tick, and each returned result is checked field by field. The
// sending side works in bursts, and the result side stalls on patterns of its
// own and once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gac_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 250;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [TDATA_W-1:0]    i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [TDATA_W-1:0]    o_m_tdata;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    generator_autostart_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // bit 0 running_sense_n, bit 1 line_fail_n
    logic [1:0] pending_ticks [$];
    t_result    predicted_outputs [$];

    int mismatch_count = 0;
    int cycle_count = 0;

    int burst_max = 1;
    int gap_max = 0;
    int burst_left = 0;
    int gap_left = 0;

    int ready_mode = 0;
    int ready_step = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left = 0;

    t_cfg       reg_cfg;
    logic       gen_running = 1'b0;
    logic       power_req = 1'b0;
    logic [4:0] stable_cnt = '0;
    logic [7:0] cool_cnt = '0;
    logic [8:0] attempt_cnt = '0;
    logic [2:0] retry_cnt = '0;
    logic [8:0] tick_cnt = '0;
    logic       cool_led = 1'b0;
    logic       run_led = 1'b0;

    function automatic t_result predict_tick(input logic run_n, input logic fail_n);
        t_result r;
        logic    running_now;
        r = '0;
        running_now = !run_n;
        if (tick_cnt <= {1'b0, reg_cfg.warmup_ticks}) begin
            tick_cnt++;
        end
        if (retry_cnt >= reg_cfg.max_retries) begin
            cool_led = 1'b0;
            run_led = 1'b0;
            r.locked_out = 1'b1;
            return r;
        end
        if (running_now && !gen_running) begin
            if (stable_cnt > {1'b0, reg_cfg.debounce_ticks}) begin
                gen_running = 1'b1;
            end else begin
                stable_cnt++;
            end
        end else begin
            gen_running = running_now;
            stable_cnt = '0;
        end
        power_req = !fail_n;
        cool_led = (cool_cnt != 0) ? !cool_led : 1'b0;
        run_led = (stable_cnt != 0) ? !run_led : gen_running;
        if (gen_running) begin
            attempt_cnt = '0;
            retry_cnt = '0;
            if (power_req) begin
                cool_cnt = '0;
            end else begin
                if (cool_cnt != COOL_SAT) begin
                    cool_cnt++;
                end
                if (cool_cnt >= reg_cfg.cooldown_ticks) begin
                    r.stop_pulse = 1'b1;
                    cool_cnt = '0;
                end
            end
        end else begin
            cool_cnt = '0;
            if (power_req && tick_cnt > {1'b0, reg_cfg.warmup_ticks} && stable_cnt == 0) begin
                if (attempt_cnt == 0) begin
                    r.start_pulse = 1'b1;
                end
                if (attempt_cnt != ATTEMPT_SAT) begin
                    attempt_cnt++;
                end
                if (attempt_cnt > {1'b0, reg_cfg.start_wait_ticks}
                        && retry_cnt < reg_cfg.max_retries) begin
                    attempt_cnt = '0;
                    retry_cnt++;
                end
            end else begin
                attempt_cnt = '0;
                retry_cnt = '0;
            end
        end
        r.cooldown_led = cool_led;
        r.running_led = run_led;
        r.request_led = power_req;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic got, input logic want);
        if (mismatch_count < 30) begin
            $display("MISMATCH %0t ns: %s got %b want %b", $time, field, got, want);
        end
        mismatch_count++;
    endtask

    // sender: take ticks from the pending queue in bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predicted_outputs.push_back(predict_tick(i_s_tdata[0], i_s_tdata[1]));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0 || pending_ticks.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left <= gap_left - 1;
                    end
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {6'b0, pending_ticks[0]};
                    pending_ticks.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, burst_max);
                        gap_left <= $urandom_range(0, gap_max);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver: stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left <= LONG_HOLD;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            ready_step <= (ready_step + 1) % 7;
            case (ready_mode)
                0: begin
                    i_m_tready <= 1'b1;
                end
                1: begin
                    i_m_tready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    i_m_tready <= ($urandom_range(0, 2) == 0);
                end
                default: begin
                    i_m_tready <= (ready_step < 3);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[5:0]);
            if (predicted_outputs.size() == 0) begin
                report_mismatch("unexpected transfer", 1'b1, 1'b0);
            end else begin
                want = predicted_outputs.pop_front();
                if (got.start_pulse !== want.start_pulse)
                    report_mismatch("start_pulse", got.start_pulse, want.start_pulse);
                if (got.stop_pulse !== want.stop_pulse)
                    report_mismatch("stop_pulse", got.stop_pulse, want.stop_pulse);
                if (got.locked_out !== want.locked_out)
                    report_mismatch("locked_out", got.locked_out, want.locked_out);
                if (got.cooldown_led !== want.cooldown_led)
                    report_mismatch("cooldown_led", got.cooldown_led, want.cooldown_led);
                if (got.running_led !== want.running_led)
                    report_mismatch("running_led", got.running_led, want.running_led);
                if (got.request_led !== want.request_led)
                    report_mismatch("request_led", got.request_led, want.request_led);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || i_s_tvalid || predicted_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        for (int k = 0; k < 5; k++) begin
            i_cfg_wr_en <= 1'b1;
            case (k)
                0: begin
                    i_cfg_idx <= CFG_DEBOUNCE;
                    i_cfg_wdata <= {4'b0, c.debounce_ticks};
                end
                1: begin
                    i_cfg_idx <= CFG_COOLDOWN;
                    i_cfg_wdata <= c.cooldown_ticks;
                end
                2: begin
                    i_cfg_idx <= CFG_START_WAIT;
                    i_cfg_wdata <= c.start_wait_ticks;
                end
                3: begin
                    i_cfg_idx <= CFG_MAX_RETRY;
                    i_cfg_wdata <= {5'b0, c.max_retries};
                end
                default: begin
                    i_cfg_idx <= CFG_WARMUP;
                    i_cfg_wdata <= c.warmup_ticks;
                end
            endcase
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        reg_cfg = c;
        @(posedge i_clk);
    endtask

    task automatic push_tick(input logic run_n, input logic fail_n);
        pending_ticks.push_back({fail_n, run_n});
    endtask

    task automatic run_phase(input t_cfg c, input int n_items, input int seg_max,
                             input int rmode, input int bmax, input int gmax,
                             input bit long_hold);
        t_cfg       unlock;
        int         queued;
        int         seg_len;
        logic [1:0] level;
        wait_drained();
        // clear a lockout that the new limit would keep
        if (retry_cnt >= c.max_retries && retry_cnt != 3'd7) begin
            unlock = reg_cfg;
            unlock.max_retries = 3'd7;
            program_regs(unlock);
            push_tick(1'b1, 1'b1);
            wait_drained();
        end
        program_regs(c);
        ready_mode = rmode;
        burst_max = bmax;
        gap_max = gmax;
        queued = 0;
        while (queued < n_items) begin
            seg_len = $urandom_range(1, seg_max);
            level = 2'($urandom_range(0, 3));
            for (int k = 0; k < seg_len && queued < n_items; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_ticks.push_back(2'($urandom_range(0, 3)));
                end else begin
                    pending_ticks.push_back(level);
                end
                queued++;
            end
        end
        if (long_hold) begin
            repeat (20) @(posedge i_clk);
            hold_ticket <= hold_ticket + 1;
        end
        wait_drained();
    endtask

    initial begin
        t_cfg phase_cfg;
        reg_cfg = '{debounce_ticks: RST_DEBOUNCE, cooldown_ticks: RST_COOLDOWN,
                    start_wait_ticks: RST_START_WAIT, max_retries: RST_MAX_RETRY,
                    warmup_ticks: RST_WARMUP};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        ready_mode = 0;
        burst_max = 64;
        gap_max = 0;
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        wait_drained();

        // zero cooldown, single retry: stop on every idle tick, then lock out
        phase_cfg = '{debounce_ticks: 4'd0, cooldown_ticks: 8'd0, start_wait_ticks: 8'd1,
                      max_retries: 3'd1, warmup_ticks: 8'd0};
        program_regs(phase_cfg);
        repeat (3) push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        repeat (3) push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        wait_drained();

        // zero retry limit holds lockout, a higher limit releases it
        phase_cfg.max_retries = 3'd0;
        program_regs(phase_cfg);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        wait_drained();
        phase_cfg.max_retries = 3'd2;
        program_regs(phase_cfg);
        push_tick(1'b1, 1'b1);
        wait_drained();

        phase_cfg = '{debounce_ticks: RST_DEBOUNCE, cooldown_ticks: RST_COOLDOWN,
                      start_wait_ticks: RST_START_WAIT, max_retries: RST_MAX_RETRY,
                      warmup_ticks: RST_WARMUP};
        run_phase(phase_cfg, 220, 120, 1, 16, 4, 1'b0);

        phase_cfg = '{debounce_ticks: 4'd0, cooldown_ticks: 8'd1, start_wait_ticks: 8'd1,
                      max_retries: 3'd1, warmup_ticks: 8'd0};
        run_phase(phase_cfg, 220, 8, 0, 64, 0, 1'b0);

        phase_cfg = '{debounce_ticks: 4'd2, cooldown_ticks: 8'd5, start_wait_ticks: 8'd10,
                      max_retries: 3'd2, warmup_ticks: 8'd3};
        run_phase(phase_cfg, 220, 30, 1, 64, 0, 1'b1);

        repeat (2) begin
            phase_cfg.debounce_ticks = 4'($urandom_range(0, 15));
            phase_cfg.cooldown_ticks = 8'($urandom_range(1, 40));
            phase_cfg.start_wait_ticks = 8'($urandom_range(1, 40));
            phase_cfg.max_retries = 3'($urandom_range(1, 6));
            phase_cfg.warmup_ticks = 8'($urandom_range(0, 40));
            run_phase(phase_cfg, 220, 60, $urandom_range(1, 3), 12, 6, 1'b0);
        end

        phase_cfg = '{debounce_ticks: 4'd15, cooldown_ticks: 8'd255, start_wait_ticks: 8'd255,
                      max_retries: 3'd7, warmup_ticks: 8'd255};
        run_phase(phase_cfg, 200, 300, 3, 8, 3, 1'b0);

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
